// ===== design/cfla_pkg.sv =====
// Shared types, constants and helpers for the coalescing free list allocator.
// No dependencies; imported by every other design file but cfla_ram.
package cfla_pkg;

   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int FREE_W   = 9;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [DATA_W-1:0] PAGE_MASK_LOW  = 32'h0000_0fff;
   localparam logic [DATA_W-1:0] PAGE_MASK_HIGH = 32'hffff_f000;
   localparam logic [DATA_W-1:0] ALL_ONES       = 32'hffff_ffff;

   localparam logic [CSR_AW-3:0] REG_ROUND_TO_PAGES = 1'd0;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_NO_FIT = 2'd1,
      ST_LOST   = 2'd2
   } status_type;

   typedef struct packed {
      logic [DATA_W-1:0] base;
      logic [DATA_W-1:0] size;
   } region_type;

   function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      logic [DATA_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DATA_W] ? ALL_ONES : s[DATA_W-1:0];
   endfunction

endpackage

// ===== design/cfla_if.sv =====
// Request and response channel interfaces of the allocator.
// Depends on cfla_pkg for field widths.
interface cfla_req_if;
   import cfla_pkg::*;
   logic                valid;
   logic                ready;
   logic                operation;
   logic [DATA_W-1:0]   addr;
   logic [DATA_W-1:0]   size;
   modport source (output valid, output operation, output addr, output size, input ready);
   modport sink   (input valid, input operation, input addr, input size, output ready);
endinterface

interface cfla_rsp_if;
   import cfla_pkg::*;
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   result_addr;
   logic [STATUS_W-1:0] status;
   logic [FREE_W-1:0]   free_entries;
   logic [DATA_W-1:0]   lost_count;
   logic [DATA_W-1:0]   lost_bytes;
   modport source (output valid, output result_addr, output status, output free_entries,
                   output lost_count, output lost_bytes, input ready);
   modport sink   (input valid, input result_addr, input status, input free_entries,
                   input lost_count, input lost_bytes, output ready);
endinterface

// ===== design/cfla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module cfla_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

// ===== design/coalescing_free_list_allocator.sv =====
// Sorted free-region table with first-fit allocate and coalescing free.
// Each entry scanned takes a read and a check, and each entry shifted a read and a
// write, as the region RAM's one read and one write port are never used together;
// a new beat is taken only in idle, once the last response is in the output register.
// Reset clears the entry count and loss counters and sets round_to_pages; the
// region RAM is not cleared. Depends on cfla_pkg, cfla_if and cfla_ram.
module coalescing_free_list_allocator #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   cfla_req_if.sink                     req_bus,
   cfla_rsp_if.source                   rsp_bus,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [cfla_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [cfla_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [cfla_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import cfla_pkg::*;

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(TABLE_ENTRIES);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_RD    = 8'b0000_0010,
      S_CHK   = 8'b0000_0100,
      S_DEC   = 8'b0000_1000,
      S_FIX   = 8'b0001_0000,
      S_MV_RD = 8'b0010_0000,
      S_MV_WR = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [DATA_W-1:0] lost_cnt_ff, lost_cnt_in;
   logic [DATA_W-1:0] lost_bytes_ff, lost_bytes_in;
   logic              round_ff, round_in;
   logic              rsp_valid_ff, rsp_valid_in;

   op_type            op_ff, op_in;
   logic [DATA_W-1:0] addr_ff, addr_in;
   logic [DATA_W-1:0] eff_ff, eff_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     kidx_ff, kidx_in;
   region_type        prev_ff, prev_in;
   region_type        kreg_ff, kreg_in;
   logic              have_k_ff, have_k_in;
   logic              mv_up_ff, mv_up_in;
   logic [DATA_W-1:0] wsize_ff, wsize_in;
   logic [DATA_W-1:0] res_ff, res_in;
   status_type        status_ff, status_in;

   logic [DATA_W-1:0] out_addr_ff, out_addr_in;
   status_type        out_status_ff, out_status_in;
   logic [FREE_W-1:0] out_free_ff, out_free_in;
   logic [DATA_W-1:0] out_lcnt_ff, out_lcnt_in;
   logic [DATA_W-1:0] out_lbytes_ff, out_lbytes_in;

   logic              ram_we, ram_re;
   logic [IW-1:0]     ram_waddr, ram_raddr;
   region_type        ram_wdata, ram_rdata;

   logic              accept;
   logic              cfg_wr;
   logic [DATA_W:0]   round_sum;
   logic              round_ok;
   logic [DATA_W-1:0] req_eff;
   logic [DATA_W:0]   prev_end;
   logic [DATA_W:0]   free_end;
   logic              prev_touch;
   logic              next_touch;
   logic [CW-1:0]     idx_m1, idx_p1;

   cfla_ram #(
      .WIDTH($bits(region_type)),
      .DEPTH(TABLE_ENTRIES)
   ) u_region_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign accept    = req_bus.valid && req_bus.ready;
   assign cfg_wr    = csr_psel && csr_penable && csr_pwrite &&
                      (csr_paddr[CSR_AW-1:2] == REG_ROUND_TO_PAGES);
   assign round_sum = {1'b0, req_bus.size} + {1'b0, PAGE_MASK_LOW};
   assign round_ok  = !round_ff || !round_sum[DATA_W];
   assign req_eff   = round_ff ? (round_sum[DATA_W-1:0] & PAGE_MASK_HIGH) : req_bus.size;
   assign prev_end  = {1'b0, prev_ff.base} + {1'b0, prev_ff.size};
   assign free_end  = {1'b0, addr_ff} + {1'b0, eff_ff};
   assign prev_touch = (idx_ff != '0) && (prev_end == {1'b0, addr_ff});
   assign next_touch = have_k_ff && (free_end == {1'b0, kreg_ff.base});
   assign idx_m1    = idx_ff - 1'b1;
   assign idx_p1    = idx_ff + 1'b1;

   assign req_bus.ready        = (state_ff == S_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_addr  = out_addr_ff;
   assign rsp_bus.status       = out_status_ff;
   assign rsp_bus.free_entries = out_free_ff;
   assign rsp_bus.lost_count   = out_lcnt_ff;
   assign rsp_bus.lost_bytes   = out_lbytes_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_AW-1:2] == REG_ROUND_TO_PAGES) ?
                       {{(CSR_DW-1){1'b0}}, round_ff} : '0;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      lost_cnt_in   = lost_cnt_ff;
      lost_bytes_in = lost_bytes_ff;
      round_in      = cfg_wr ? csr_pwdata[0] : round_ff;
      rsp_valid_in  = (rsp_valid_ff && rsp_bus.ready) ? 1'b0 : rsp_valid_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      eff_in        = eff_ff;
      idx_in        = idx_ff;
      kidx_in       = kidx_ff;
      prev_in       = prev_ff;
      kreg_in       = kreg_ff;
      have_k_in     = have_k_ff;
      mv_up_in      = mv_up_ff;
      wsize_in      = wsize_ff;
      res_in        = res_ff;
      status_in     = status_ff;
      out_addr_in   = out_addr_ff;
      out_status_in = out_status_ff;
      out_free_in   = out_free_ff;
      out_lcnt_in   = out_lcnt_ff;
      out_lbytes_in = out_lbytes_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff[IW-1:0];
      ram_wdata     = ram_rdata;
      ram_re        = 1'b0;
      ram_raddr     = idx_ff[IW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = op_type'(req_bus.operation);
               addr_in   = req_bus.addr;
               eff_in    = req_eff;
               idx_in    = '0;
               res_in    = '0;
               status_in = ST_OK;
               if (!round_ok) begin
                  if (op_type'(req_bus.operation) == OP_ALLOC) begin
                     status_in = ST_NO_FIT;
                  end else begin
                     status_in     = ST_LOST;
                     lost_cnt_in   = sat_add(lost_cnt_ff, DATA_W'(1));
                     lost_bytes_in = sat_add(lost_bytes_ff, req_bus.size);
                  end
                  state_in = S_DONE;
               end else if (op_type'(req_bus.operation) == OP_FREE && req_eff == '0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            if (idx_ff < count_ff) begin
               ram_re   = 1'b1;
               state_in = S_CHK;
            end else if (op_ff == OP_ALLOC) begin
               status_in = ST_NO_FIT;
               state_in  = S_DONE;
            end else begin
               have_k_in = 1'b0;
               state_in  = S_DEC;
            end
         end
         S_CHK: begin
            if (op_ff == OP_ALLOC) begin
               if (ram_rdata.size >= eff_ff) begin
                  res_in = ram_rdata.base;
                  if (ram_rdata.size == eff_ff) begin
                     count_in = count_ff - 1'b1;
                     mv_up_in = 1'b0;
                     state_in = S_MV_RD;
                  end else begin
                     ram_we         = 1'b1;
                     ram_wdata.base = ram_rdata.base + eff_ff;
                     ram_wdata.size = ram_rdata.size - eff_ff;
                     state_in       = S_DONE;
                  end
               end else begin
                  idx_in   = idx_p1;
                  state_in = S_RD;
               end
            end else begin
               if (ram_rdata.base > addr_ff) begin
                  kreg_in   = ram_rdata;
                  have_k_in = 1'b1;
                  state_in  = S_DEC;
               end else begin
                  prev_in  = ram_rdata;
                  idx_in   = idx_p1;
                  state_in = S_RD;
               end
            end
         end
         S_DEC: begin
            if (prev_touch) begin
               if (next_touch) begin
                  wsize_in = sat_add(prev_ff.size, eff_ff);
                  state_in = S_FIX;
               end else begin
                  ram_we         = 1'b1;
                  ram_waddr      = idx_m1[IW-1:0];
                  ram_wdata.base = prev_ff.base;
                  ram_wdata.size = sat_add(prev_ff.size, eff_ff);
                  state_in       = S_DONE;
               end
            end else if (next_touch) begin
               ram_we         = 1'b1;
               ram_wdata.base = addr_ff;
               ram_wdata.size = sat_add(kreg_ff.size, eff_ff);
               state_in       = S_DONE;
            end else if (count_ff < COUNT_MAX) begin
               kidx_in  = idx_ff;
               idx_in   = count_ff;
               mv_up_in = 1'b1;
               state_in = S_MV_RD;
            end else begin
               status_in     = ST_LOST;
               lost_cnt_in   = sat_add(lost_cnt_ff, DATA_W'(1));
               lost_bytes_in = sat_add(lost_bytes_ff, eff_ff);
               state_in      = S_DONE;
            end
         end
         S_FIX: begin
            ram_we         = 1'b1;
            ram_waddr      = idx_m1[IW-1:0];
            ram_wdata.base = prev_ff.base;
            ram_wdata.size = sat_add(wsize_ff, kreg_ff.size);
            count_in       = count_ff - 1'b1;
            mv_up_in       = 1'b0;
            state_in       = S_MV_RD;
         end
         S_MV_RD: begin
            if (mv_up_ff) begin
               if (idx_ff > kidx_ff) begin
                  ram_re    = 1'b1;
                  ram_raddr = idx_m1[IW-1:0];
                  state_in  = S_MV_WR;
               end else begin
                  ram_we         = 1'b1;
                  ram_wdata.base = addr_ff;
                  ram_wdata.size = eff_ff;
                  count_in       = count_ff + 1'b1;
                  state_in       = S_DONE;
               end
            end else begin
               if (idx_ff < count_ff) begin
                  ram_re    = 1'b1;
                  ram_raddr = idx_p1[IW-1:0];
                  state_in  = S_MV_WR;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_MV_WR: begin
            ram_we   = 1'b1;
            idx_in   = mv_up_ff ? idx_m1 : idx_p1;
            state_in = S_MV_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               out_addr_in   = res_ff;
               out_status_in = status_ff;
               out_free_in   = FREE_W'(count_ff);
               out_lcnt_in   = lost_cnt_ff;
               out_lbytes_in = lost_bytes_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         lost_cnt_ff   <= '0;
         lost_bytes_ff <= '0;
         round_ff      <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         lost_cnt_ff   <= lost_cnt_in;
         lost_bytes_ff <= lost_bytes_in;
         round_ff      <= round_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      eff_ff        <= eff_in;
      idx_ff        <= idx_in;
      kidx_ff       <= kidx_in;
      prev_ff       <= prev_in;
      kreg_ff       <= kreg_in;
      have_k_ff     <= have_k_in;
      mv_up_ff      <= mv_up_in;
      wsize_ff      <= wsize_in;
      res_ff        <= res_in;
      status_ff     <= status_in;
      out_addr_ff   <= out_addr_in;
      out_status_ff <= out_status_in;
      out_free_ff   <= out_free_in;
      out_lcnt_ff   <= out_lcnt_in;
      out_lbytes_ff <= out_lbytes_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("entry count beyond table size");

   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("region RAM read and write in one cycle");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted beat left the block idle");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + 1'b1) ||
      (count_ff == $past(count_ff) - 1'b1))
      else $error("entry count jumped by more than one");

   a_lost_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_status_ff != ST_OK) |-> (out_addr_ff == '0))
      else $error("failed beat carries a nonzero address");

endmodule

// ===== tb/coalescing_free_list_allocator_test.sv =====
// Self-checking testbench for the coalescing free list allocator: directed and random
// allocate/free beats are checked against a predicted copy of the sorted region table.
// Depends on cfla_pkg, cfla_if and the coalescing_free_list_allocator RTL.
module coalescing_free_list_allocator_test;
   import cfla_pkg::*;

   localparam int TABLE_SIZE = 256;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_ITEMS = 100;
   localparam logic [DATA_W-1:0] PAGE_BYTES = 32'h0000_1000;
   localparam logic [DATA_W-1:0] FILL_BASE = 32'h4000_0000;

   typedef struct {
      logic [DATA_W-1:0] result_addr;
      status_type        status;
      logic [FREE_W-1:0] free_entries;
      logic [DATA_W-1:0] lost_count;
      logic [DATA_W-1:0] lost_bytes;
   } outcome_type;

   class free_list_scoreboard;
      logic [DATA_W-1:0] base_of [TABLE_SIZE];
      logic [DATA_W-1:0] size_of [TABLE_SIZE];
      int unsigned       entries = 0;
      logic [DATA_W-1:0] lost_frees = '0;
      logic [DATA_W-1:0] lost_total_bytes = '0;
      bit                round_pages = 1'b1;
      logic [DATA_W-1:0] granted_size = '0;
      outcome_type       pending [$];
      int unsigned       mismatches = 0;

      function logic [DATA_W-1:0] clamp_sum(logic [DATA_W-1:0] a, logic [DATA_W:0] b);
         logic [DATA_W+1:0] s;
         s = {2'b00, a} + {1'b0, b};
         return (s > {2'b00, ALL_ONES}) ? ALL_ONES : s[DATA_W-1:0];
      endfunction

      function void drop_entry(int unsigned k);
         int unsigned j;
         entries--;
         for (j = k; j < entries; j++) begin
            base_of[j] = base_of[j+1];
            size_of[j] = size_of[j+1];
         end
      endfunction

      function logic [DATA_W-1:0] take_region(logic [DATA_W-1:0] req, output status_type st);
         int unsigned k;
         logic [DATA_W-1:0] base;
         st = ST_NO_FIT;
         for (k = 0; k < entries; k++) begin
            if (size_of[k] >= req) begin
               base = base_of[k];
               base_of[k] = base + req;
               size_of[k] = size_of[k] - req;
               if (size_of[k] == '0) drop_entry(k);
               st = ST_OK;
               return base;
            end
         end
         return '0;
      endfunction

      function status_type give_region(logic [DATA_W-1:0] a, logic [DATA_W-1:0] sz);
         int unsigned k, j;
         logic [DATA_W:0] span_end;
         span_end = {1'b0, a} + {1'b0, sz};
         if (sz == '0) return ST_OK;
         k = 0;
         while (k < entries && base_of[k] <= a) k++;
         if (k > 0 && {1'b0, base_of[k-1]} + {1'b0, size_of[k-1]} == {1'b0, a}) begin
            size_of[k-1] = clamp_sum(size_of[k-1], {1'b0, sz});
            if (k < entries && span_end == {1'b0, base_of[k]}) begin
               size_of[k-1] = clamp_sum(size_of[k-1], {1'b0, size_of[k]});
               drop_entry(k);
            end
            return ST_OK;
         end
         if (k < entries && span_end == {1'b0, base_of[k]}) begin
            base_of[k] = a;
            size_of[k] = clamp_sum(size_of[k], {1'b0, sz});
            return ST_OK;
         end
         if (entries < TABLE_SIZE) begin
            for (j = entries; j > k; j--) begin
               base_of[j] = base_of[j-1];
               size_of[j] = size_of[j-1];
            end
            entries++;
            base_of[k] = a;
            size_of[k] = sz;
            return ST_OK;
         end
         lost_frees = clamp_sum(lost_frees, (DATA_W+1)'(1));
         lost_total_bytes = clamp_sum(lost_total_bytes, {1'b0, sz});
         return ST_LOST;
      endfunction

      function outcome_type note_request(op_type op, logic [DATA_W-1:0] a,
                                         logic [DATA_W-1:0] sz);
         outcome_type o;
         status_type st;
         logic [DATA_W:0] padded;
         logic [DATA_W-1:0] eff;
         bit fits;
         eff = sz;
         fits = 1'b1;
         if (round_pages) begin
            padded = {1'b0, sz} + {1'b0, PAGE_MASK_LOW};
            fits = !padded[DATA_W];
            eff = padded[DATA_W-1:0] & PAGE_MASK_HIGH;
         end
         granted_size = eff;
         o.result_addr = '0;
         st = ST_OK;
         if (op == OP_ALLOC) begin
            if (fits) o.result_addr = take_region(eff, st);
            else st = ST_NO_FIT;
         end else if (fits) begin
            st = give_region(a, eff);
         end else begin
            lost_frees = clamp_sum(lost_frees, (DATA_W+1)'(1));
            lost_total_bytes = clamp_sum(lost_total_bytes, {1'b0, sz});
            st = ST_LOST;
         end
         o.status = st;
         o.free_entries = entries[FREE_W-1:0];
         o.lost_count = lost_frees;
         o.lost_bytes = lost_total_bytes;
         pending.push_back(o);
         return o;
      endfunction

      function void note_mismatch(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", msg);
      endfunction

      function void check_response(logic [DATA_W-1:0] addr, logic [STATUS_W-1:0] st,
                                   logic [FREE_W-1:0] n, logic [DATA_W-1:0] lc,
                                   logic [DATA_W-1:0] lb);
         outcome_type o;
         if (pending.size() == 0) begin
            note_mismatch($sformatf("unexpected beat addr %h status %0d entries %0d",
                                    addr, st, n));
            return;
         end
         o = pending.pop_front();
         if (addr !== o.result_addr || st !== o.status || n !== o.free_entries ||
             lc !== o.lost_count || lb !== o.lost_bytes)
            note_mismatch($sformatf({"expected addr %h status %0d entries %0d lost %h/%h, ",
                                     "got addr %h status %0d entries %0d lost %h/%h"},
                                    o.result_addr, o.status, o.free_entries, o.lost_count,
                                    o.lost_bytes, addr, st, n, lc, lb));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata, csr_prdata;

   cfla_req_if req_bus ();
   cfla_rsp_if rsp_bus ();

   free_list_scoreboard ledger;
   region_type held [$];
   int unsigned items_sent = 0;
   int unsigned beats_seen = 0;
   int unsigned hold_left = 0;
   bit held_off = 1'b0;

   coalescing_free_list_allocator #(.TABLE_ENTRIES(TABLE_SIZE)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         ledger.check_response(rsp_bus.result_addr, rsp_bus.status, rsp_bus.free_entries,
                               rsp_bus.lost_count, rsp_bus.lost_bytes);
         beats_seen++;
         if (beats_seen == 150 && !held_off) begin
            hold_left = HOLD_OFF_CYCLES;
            held_off = 1'b1;
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (beats_seen >= 600 && beats_seen < 760) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= 15);
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_item(input op_type op, input logic [DATA_W-1:0] a,
                            input logic [DATA_W-1:0] sz, output outcome_type o);
      while (!(items_sent >= 500 && items_sent < 650) && $urandom_range(99) < 15) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.addr <= a;
      req_bus.size <= sz;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      o = ledger.note_request(op, a, sz);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (ledger.pending.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic set_rounding(input bit on);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_ROUND_TO_PAGES, 2'b00};
      csr_pwdata <= CSR_DW'(on);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      ledger.round_pages = on;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      if (csr_prdata !== CSR_DW'(on))
         ledger.note_mismatch($sformatf("round_to_pages read %h, expected %0d", csr_prdata, on));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_item();
      int unsigned pick, idx;
      logic [DATA_W-1:0] sz, half;
      region_type blk;
      outcome_type o;
      pick = $urandom_range(99);
      if (pick < 8) begin
         send_item(op_type'($urandom_range(1)), $urandom, $urandom >> $urandom_range(0, 31), o);
      end else if (pick < 52) begin
         if (pick < 20) sz = $urandom_range(0, 32'h4000);
         else sz = $urandom_range(1, 8) * PAGE_BYTES;
         send_item(OP_ALLOC, $urandom, sz, o);
         if (o.status == ST_OK && ledger.granted_size != '0)
            held.push_back('{base: o.result_addr, size: ledger.granted_size});
      end else if (held.size() > 0) begin
         idx = $urandom_range(held.size() - 1);
         blk = held[idx];
         held.delete(idx);
         if (blk.size > PAGE_BYTES && $urandom_range(3) == 0) begin
            half = blk.size >> 1;
            send_item(OP_FREE, blk.base + half, blk.size - half, o);
            send_item(OP_FREE, blk.base, half, o);
         end else begin
            send_item(OP_FREE, blk.base, blk.size, o);
         end
      end else begin
         send_item(OP_FREE, 32'h0010_0000 + $urandom_range(0, 255) * PAGE_BYTES,
                   $urandom_range(1, 16) * PAGE_BYTES, o);
      end
   endtask

   initial begin
      outcome_type seen;
      int unsigned target;
      ledger = new;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.operation <= OP_ALLOC;
      req_bus.addr <= '0;
      req_bus.size <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(OP_ALLOC, '0, '0, seen);
      send_item(OP_FREE, 32'h0000_1000, '0, seen);
      send_item(OP_ALLOC, ALL_ONES, ALL_ONES, seen);
      send_item(OP_FREE, 32'h0000_5000, 32'hffff_f001, seen);
      send_item(OP_FREE, 32'h0001_0000, 32'h1, seen);
      send_item(OP_FREE, 32'h0001_2000, PAGE_BYTES, seen);
      send_item(OP_FREE, 32'h0001_1000, 32'h800, seen);
      send_item(OP_FREE, 32'h0000_8000, PAGE_BYTES, seen);
      send_item(OP_FREE, 32'h0000_9000, PAGE_BYTES, seen);
      send_item(OP_FREE, 32'h0000_e000, 32'h2000, seen);
      send_item(OP_ALLOC, '0, '0, seen);
      send_item(OP_ALLOC, '0, 32'h1001, seen);
      send_item(OP_ALLOC, '0, 32'h0010_0000, seen);
      send_item(OP_ALLOC, '0, 32'hffff_f000, seen);
      wait_drained();
      set_rounding(1'b0);
      send_item(OP_FREE, 32'hffff_ff00, 32'h0001_0000, seen);
      send_item(OP_ALLOC, '0, 32'h6000, seen);
      send_item(OP_FREE, '0, 32'h10, seen);
      send_item(OP_FREE, 32'h10, ALL_ONES, seen);
      send_item(OP_FREE, '0, '0, seen);
      send_item(OP_ALLOC, '0, ALL_ONES, seen);
      send_item(OP_FREE, 32'hffff_fff0, 32'h10, seen);
      send_item(OP_FREE, '0, 32'h10, seen);
      wait_drained();
      set_rounding(1'b1);

      for (int i = 0; ledger.entries < TABLE_SIZE && i < 2 * TABLE_SIZE; i++)
         send_item(OP_FREE, FILL_BASE + i * 32'h2000, PAGE_BYTES, seen);
      send_item(OP_FREE, 32'h7000_0000, PAGE_BYTES, seen);
      send_item(OP_FREE, 32'h7000_0000, 32'hffff_f001, seen);
      wait_drained();
      set_rounding(1'b0);
      send_item(OP_FREE, 32'h7100_0000, ALL_ONES, seen);
      send_item(OP_FREE, 32'h7100_0000, ALL_ONES, seen);
      send_item(OP_FREE, FILL_BASE + PAGE_BYTES, PAGE_BYTES, seen);
      send_item(OP_FREE, 32'h7000_0000, 32'h100, seen);
      send_item(OP_FREE, 32'h7200_0000, 32'h100, seen);
      while (ledger.entries > 0)
         send_item(OP_ALLOC, $urandom, ledger.size_of[0], seen);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         set_rounding(phase % 2 == 0);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) random_item();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/cfla_pkg.sv
design/cfla_if.sv
design/cfla_ram.sv
design/coalescing_free_list_allocator.sv
tb/coalescing_free_list_allocator_test.sv
